>>> rtl/fdm_pkg.sv
package fdm_pkg;

    typedef struct packed {
        logic differ;
        logic yneg;
        logic zero;
        logic ovf;
    } fdm_flags_t;

endpackage

>>> rtl/fdm_cell.sv
module fdm_cell
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  prev_valid,
    input  logic [DATA_WIDTH-1:0] prev_rem,
    input  logic [DATA_WIDTH-1:0] prev_dq,
    input  logic [DATA_WIDTH-1:0] prev_ay,
    input  fdm_flags_t            prev_flags,
    output logic                  valid,
    output logic [DATA_WIDTH-1:0] rem,
    output logic [DATA_WIDTH-1:0] dq,
    output logic [DATA_WIDTH-1:0] ay,
    output fdm_flags_t            flags
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] dq_reg;
    logic [DATA_WIDTH-1:0] dq_next;
    logic [DATA_WIDTH-1:0] ay_reg;
    fdm_flags_t            flags_reg;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb
    begin
        trial    = {prev_rem, prev_dq[DATA_WIDTH-1]};
        diff     = trial - {1'b0, prev_ay};
        ge       = ~diff[DATA_WIDTH];
        rem_next = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        dq_next  = {prev_dq[DATA_WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg   <= rem_next;
            dq_reg    <= dq_next;
            ay_reg    <= prev_ay;
            flags_reg <= prev_flags;
        end
    end

    assign valid = valid_reg;
    assign rem   = rem_reg;
    assign dq    = dq_reg;
    assign ay    = ay_reg;
    assign flags = flags_reg;

endmodule

>>> rtl/fdm_out_buf.sv
module fdm_out_buf
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [DATA_WIDTH-1:0]        rem,
    input  logic [DATA_WIDTH-1:0]        dq,
    input  logic [DATA_WIDTH-1:0]        ay,
    input  fdm_flags_t                   flags,
    output logic                         full,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic signed [DATA_WIDTH-1:0] modulus,
    output logic                         zero_divisor,
    output logic                         overflowed
);

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    logic [DATA_WIDTH-1:0] q0_reg;
    logic [DATA_WIDTH-1:0] q0_next;
    logic [DATA_WIDTH-1:0] m0_reg;
    logic [DATA_WIDTH-1:0] m0_next;
    logic [1:0]            f0_reg;
    logic [1:0]            f0_next;
    logic [DATA_WIDTH-1:0] q1_reg;
    logic [DATA_WIDTH-1:0] q1_next;
    logic [DATA_WIDTH-1:0] m1_reg;
    logic [DATA_WIDTH-1:0] m1_next;
    logic [1:0]            f1_reg;
    logic [1:0]            f1_next;
    logic [DATA_WIDTH-1:0] q_res;
    logic [DATA_WIDTH-1:0] m_res;
    logic [1:0]            f_res;
    logic                  r_zero;
    logic                  pop;

    // Turn the unsigned quotient and remainder into floored signed results.
    always_comb
    begin
        r_zero = (rem == '0);
        if (flags.differ)
        begin
            q_res = r_zero ? ('0 - dq) : ~dq;
        end
        else
        begin
            q_res = dq;
        end
        if (r_zero)
        begin
            m_res = '0;
        end
        else if (flags.differ)
        begin
            m_res = flags.yneg ? (rem - ay) : (ay - rem);
        end
        else
        begin
            m_res = flags.yneg ? ('0 - rem) : rem;
        end
        if (flags.zero)
        begin
            q_res = '0;
            m_res = '0;
        end
        f_res = {flags.zero, flags.ovf};
    end

    assign pop = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        m0_next  = m0_reg;
        f0_next  = f0_reg;
        q1_next  = q1_reg;
        m1_next  = m1_reg;
        f1_next  = f1_reg;
        if (pop && push)
        begin
            if (cnt_reg == 2'd1)
            begin
                q0_next = q_res;
                m0_next = m_res;
                f0_next = f_res;
            end
            else
            begin
                q0_next = q1_reg;
                m0_next = m1_reg;
                f0_next = f1_reg;
                q1_next = q_res;
                m1_next = m_res;
                f1_next = f_res;
            end
        end
        else if (pop)
        begin
            q0_next  = q1_reg;
            m0_next  = m1_reg;
            f0_next  = f1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                q0_next = q_res;
                m0_next = m_res;
                f0_next = f_res;
            end
            else
            begin
                q1_next = q_res;
                m1_next = m_res;
                f1_next = f_res;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        m0_reg <= m0_next;
        f0_reg <= f0_next;
        q1_reg <= q1_next;
        m1_reg <= m1_next;
        f1_reg <= f1_next;
    end

    assign full         = (cnt_reg == 2'd2);
    assign out_valid    = (cnt_reg != 2'd0);
    assign quotient     = q0_reg;
    assign modulus      = m0_reg;
    assign zero_divisor = f0_reg[1];
    assign overflowed   = f0_reg[0];

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("result pushed into a full output buffer");

    a_zero_results: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_divisor) |-> (quotient == '0 && modulus == '0 && !overflowed))
        else $error("zero divisor result is not cleared");

    a_ovf_results: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflowed) |-> (quotient == MOST_NEG && modulus == '0))
        else $error("overflow result is not the wrapped quotient");
`endif

endmodule

>>> rtl/floored_divide_modulo.sv
// Throughput: one request per cycle; the pipeline is one operand register, DATA_WIDTH
// restoring-division cells, and a two-entry output buffer, and it stalls only when
// both buffer entries hold results that have not been taken.
// Reset clears the stage valid bits and the buffer count; no other state is reset.
module floored_divide_modulo
    import fdm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic signed [DATA_WIDTH-1:0] modulus,
    output logic                         zero_divisor,
    output logic                         overflowed
);

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  adv;
    logic                  full;
    logic [DATA_WIDTH-1:0] x_u;
    logic [DATA_WIDTH-1:0] y_u;
    logic [DATA_WIDTH-1:0] ax_next;
    logic [DATA_WIDTH-1:0] ay_next;
    fdm_flags_t            flags_next;
    logic                  s0_valid_reg;
    logic [DATA_WIDTH-1:0] s0_ax_reg;
    logic [DATA_WIDTH-1:0] s0_ay_reg;
    fdm_flags_t            s0_flags_reg;

    logic                  valid_chain [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_chain   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dq_chain    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] ay_chain    [0:DATA_WIDTH];
    fdm_flags_t            flags_chain [0:DATA_WIDTH];

    assign adv      = !full;
    assign in_ready = adv;

    always_comb
    begin
        x_u               = dividend;
        y_u               = divisor;
        ax_next           = x_u[DATA_WIDTH-1] ? ('0 - x_u) : x_u;
        ay_next           = y_u[DATA_WIDTH-1] ? ('0 - y_u) : y_u;
        flags_next.differ = x_u[DATA_WIDTH-1] ^ y_u[DATA_WIDTH-1];
        flags_next.yneg   = y_u[DATA_WIDTH-1];
        flags_next.zero   = (y_u == '0);
        flags_next.ovf    = (x_u == MOST_NEG) && (y_u == '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_ax_reg    <= ax_next;
            s0_ay_reg    <= ay_next;
            s0_flags_reg <= flags_next;
        end
    end

    assign valid_chain[0] = s0_valid_reg;
    assign rem_chain[0]   = '0;
    assign dq_chain[0]    = s0_ax_reg;
    assign ay_chain[0]    = s0_ay_reg;
    assign flags_chain[0] = s0_flags_reg;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        fdm_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (valid_chain[i]),
            .prev_rem   (rem_chain[i]),
            .prev_dq    (dq_chain[i]),
            .prev_ay    (ay_chain[i]),
            .prev_flags (flags_chain[i]),
            .valid      (valid_chain[i+1]),
            .rem        (rem_chain[i+1]),
            .dq         (dq_chain[i+1]),
            .ay         (ay_chain[i+1]),
            .flags      (flags_chain[i+1])
        );
    end

    fdm_out_buf #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (adv && valid_chain[DATA_WIDTH]),
        .rem          (rem_chain[DATA_WIDTH]),
        .dq           (dq_chain[DATA_WIDTH]),
        .ay           (ay_chain[DATA_WIDTH]),
        .flags        (flags_chain[DATA_WIDTH]),
        .full         (full),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quotient     (quotient),
        .modulus      (modulus),
        .zero_divisor (zero_divisor),
        .overflowed   (overflowed)
    );

endmodule
